>>> rtl/cssweep_pkg.sv
`default_nettype none
package cssweep_pkg;

  // Sign of a difference, taken from a compare of the two samples.
  typedef struct packed {
    logic pos;
    logic neg;
  } sgn_t;

  // Per-cell control that travels from the evaluation logic to the seed logic.
  typedef struct packed {
    logic have;
    logic first_column;
    logic column_start;
  } cell_ctl_t;

  typedef enum logic {
    ACT_NEW   = 1'b0,
    ACT_WIDEN = 1'b1
  } action_e;

  function automatic logic sgn_zero(input sgn_t a);
    return !a.pos && !a.neg;
  endfunction

  // True when a equals the negation of b. Two zero signs count as opposed.
  function automatic logic sgn_opposed(input sgn_t a, input sgn_t b);
    return (a.pos && b.neg) || (a.neg && b.pos) || (sgn_zero(a) && sgn_zero(b));
  endfunction

  function automatic logic sgn_same(input sgn_t a, input sgn_t b);
    return (a.pos == b.pos) && (a.neg == b.neg);
  endfunction

endpackage
`default_nettype wire

>>> rtl/contour_seed_cell_sweep.sv
// Seed selection for contour extraction over a 2D grid walked column by column: each input
// beat is one cell with its four corner samples, its linear index and its position flags, and
// each cell yields at most one output beat, either a new seed (action 0, numbered by an internal
// seed counter that wraps) or a widening of the seed opened by the cell just below (action 1,
// cell_id 0), carrying the min and max of the edge value ranges the cell contributes. The block
// takes one beat per cycle while the output side is not stalled: a cell sits in an input
// register while the sign compares and min/max selection run, and its result lands in an output
// register. Cells that contribute no range produce no output beat. Stall on the output side holds
// the output register and, through it, the input register; the input stall is raised only
// while both are full.
`default_nettype none
module contour_seed_cell_sweep #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0] corner_low_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0] corner_low_right_i,
  input  wire logic signed [SAMPLE_BITS-1:0] corner_up_left_i,
  input  wire logic signed [SAMPLE_BITS-1:0] corner_up_right_i,
  input  wire logic [INDEX_BITS-1:0]         cell_number_i,
  input  wire logic                          column_start_i,
  input  wire logic                          first_column_i,
  input  wire logic                          last_row_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               action_o,
  output logic [INDEX_BITS-1:0]              seed_number_o,
  output logic [INDEX_BITS-1:0]              cell_id_o,
  output logic signed [SAMPLE_BITS-1:0]      range_low_o,
  output logic signed [SAMPLE_BITS-1:0]      range_high_o
);
  import cssweep_pkg::*;

  // Input register holding the cell currently being evaluated.
  logic                          s1_valid_q, s1_valid_d;
  logic signed [SAMPLE_BITS-1:0] ll_q, lr_q, ul_q, ur_q;
  logic [INDEX_BITS-1:0]         cell_q;
  logic                          column_start_q, first_column_q, last_row_q;

  logic                          out_free;
  logic                          step;
  logic                          in_take;
  cell_ctl_t                     ctl;
  logic signed [SAMPLE_BITS-1:0] lo, hi;

  // The cell in the input register moves on (and updates the sweep state) whenever the output
  // register can take its result, even if the cell turns out to produce none.
  assign step       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_take) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      ll_q           <= corner_low_left_i;
      lr_q           <= corner_low_right_i;
      ul_q           <= corner_up_left_i;
      ur_q           <= corner_up_right_i;
      cell_q         <= cell_number_i;
      column_start_q <= column_start_i;
      first_column_q <= first_column_i;
      last_row_q     <= last_row_i;
    end
  end

  // Gradient sign tests, the keep-flat flag and the range collection.
  cssweep_eval #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_eval (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .ll_i          (ll_q),
    .lr_i          (lr_q),
    .ul_i          (ul_q),
    .ur_i          (ur_q),
    .column_start_i(column_start_q),
    .first_column_i(first_column_q),
    .last_row_i    (last_row_q),
    .ctl_o         (ctl),
    .range_low_o   (lo),
    .range_high_o  (hi)
  );

  // Pending-seed link, seed counter and the output register.
  cssweep_seed #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .INDEX_BITS (INDEX_BITS)
  ) u_seed (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .ctl_i        (ctl),
    .cell_i       (cell_q),
    .lo_i         (lo),
    .hi_i         (hi),
    .free_o       (out_free),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .action_o     (action_o),
    .seed_number_o(seed_number_o),
    .cell_id_o    (cell_id_o),
    .range_low_o  (range_low_o),
    .range_high_o (range_high_o)
  );

endmodule
`default_nettype wire

>>> rtl/cssweep_eval.sv
`default_nettype none
module cssweep_eval #(
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic signed [SAMPLE_BITS-1:0] ll_i,
  input  wire logic signed [SAMPLE_BITS-1:0] lr_i,
  input  wire logic signed [SAMPLE_BITS-1:0] ul_i,
  input  wire logic signed [SAMPLE_BITS-1:0] ur_i,
  input  wire logic                          column_start_i,
  input  wire logic                          first_column_i,
  input  wire logic                          last_row_i,
  output cssweep_pkg::cell_ctl_t             ctl_o,
  output logic signed [SAMPLE_BITS-1:0]      range_low_o,
  output logic signed [SAMPLE_BITS-1:0]      range_high_o
);
  import cssweep_pkg::*;

  logic keep_flat_q;
  logic keep_flat_d;

  sgn_t sx, sya, syb, sx2;

  logic signed [SAMPLE_BITS-1:0] left_mn, left_mx;
  logic signed [SAMPLE_BITS-1:0] bot_mn, bot_mx;
  logic signed [SAMPLE_BITS-1:0] top_mn, top_mx;
  logic signed [SAMPLE_BITS-1:0] lo, hi;
  logic                          have;
  logic                          kf;

  function automatic sgn_t sgn_of(input logic signed [SAMPLE_BITS-1:0] a,
                                  input logic signed [SAMPLE_BITS-1:0] b);
    sgn_t s;
    s.pos = a > b;
    s.neg = a < b;
    return s;
  endfunction

  assign sx  = sgn_of(lr_i, ll_i);
  assign sya = sgn_of(ul_i, ll_i);
  assign syb = sgn_of(ur_i, lr_i);
  assign sx2 = sgn_of(ur_i, ul_i);

  assign left_mn = (ll_i < ul_i) ? ll_i : ul_i;
  assign left_mx = (ll_i < ul_i) ? ul_i : ll_i;
  assign bot_mn  = (ll_i < lr_i) ? ll_i : lr_i;
  assign bot_mx  = (ll_i < lr_i) ? lr_i : ll_i;
  assign top_mn  = (ul_i < ur_i) ? ul_i : ur_i;
  assign top_mx  = (ul_i < ur_i) ? ur_i : ul_i;

  always_comb begin
    have = 1'b0;
    lo   = left_mn;
    hi   = left_mx;
    kf   = column_start_i || keep_flat_q;

    // The left boundary edge counts only when its ends differ.
    if (first_column_i && (ll_i != ul_i)) begin
      have = 1'b1;
    end

    // The bottom edge counts when the gradient turns while still flat.
    if (kf && !(sgn_zero(sya) && sgn_zero(syb)) &&
        (sgn_opposed(sx, sya) || sgn_opposed(sx, syb))) begin
      if (!have) begin
        lo = bot_mn;
        hi = bot_mx;
      end else begin
        if (bot_mn < lo) lo = bot_mn;
        if (bot_mx > hi) hi = bot_mx;
      end
      have = 1'b1;
      kf   = 1'b0;
    end

    if (last_row_i) begin
      if (kf) begin
        if (!have) begin
          lo = top_mn;
          hi = top_mx;
        end else begin
          if (top_mn < lo) lo = top_mn;
          if (top_mx > hi) hi = top_mx;
        end
        have = 1'b1;
      end
    end else if (!kf) begin
      if (!sgn_zero(sx2) && (sgn_same(sx2, sya) || sgn_same(sx2, syb))) begin
        kf = 1'b1;
      end
    end else if (sgn_opposed(sx2, sya) || sgn_opposed(sx2, syb)) begin
      kf = 1'b0;
    end
  end

  assign keep_flat_d = step_i ? kf : keep_flat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_flat_q <= 1'b1;
    end else begin
      keep_flat_q <= keep_flat_d;
    end
  end

  assign ctl_o.have         = have;
  assign ctl_o.first_column = first_column_i;
  assign ctl_o.column_start = column_start_i;
  assign range_low_o        = lo;
  assign range_high_o       = hi;

endmodule
`default_nettype wire

>>> rtl/cssweep_seed.sv
`default_nettype none
module cssweep_seed #(
  parameter int SAMPLE_BITS = 16,
  parameter int INDEX_BITS  = 20
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire cssweep_pkg::cell_ctl_t        ctl_i,
  input  wire logic [INDEX_BITS-1:0]         cell_i,
  input  wire logic signed [SAMPLE_BITS-1:0] lo_i,
  input  wire logic signed [SAMPLE_BITS-1:0] hi_i,
  output logic                               free_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               action_o,
  output logic [INDEX_BITS-1:0]              seed_number_o,
  output logic [INDEX_BITS-1:0]              cell_id_o,
  output logic signed [SAMPLE_BITS-1:0]      range_low_o,
  output logic signed [SAMPLE_BITS-1:0]      range_high_o
);
  import cssweep_pkg::*;

  logic                          pending_valid_q, pending_valid_d;
  logic [INDEX_BITS-1:0]         pending_seed_q, pending_seed_d;
  logic [INDEX_BITS-1:0]         seed_counter_q, seed_counter_d;
  logic                          out_valid_q, out_valid_d;
  action_e                       action_q, action_d;
  logic [INDEX_BITS-1:0]         seed_number_q, seed_number_d;
  logic [INDEX_BITS-1:0]         cell_id_q, cell_id_d;
  logic signed [SAMPLE_BITS-1:0] range_low_q, range_high_q;
  logic                          pv0;

  assign free_o = !out_valid_q || !out_stall_i;

  always_comb begin
    pv0             = pending_valid_q && !ctl_i.column_start;
    pending_valid_d = pending_valid_q;
    pending_seed_d  = pending_seed_q;
    seed_counter_d  = seed_counter_q;
    action_d        = action_q;
    seed_number_d   = seed_number_q;
    cell_id_d       = cell_id_q;
    out_valid_d     = out_valid_q && out_stall_i;

    if (step_i) begin
      out_valid_d = ctl_i.have;
      if (!ctl_i.have) begin
        pending_valid_d = 1'b0;
      end else if (!pv0) begin
        action_d        = ACT_NEW;
        seed_number_d   = seed_counter_q;
        cell_id_d       = cell_i;
        pending_valid_d = !ctl_i.first_column;
        if (!ctl_i.first_column) begin
          pending_seed_d = seed_counter_q;
        end
        seed_counter_d  = seed_counter_q + 1'b1;
      end else begin
        action_d        = ACT_WIDEN;
        seed_number_d   = pending_seed_q;
        cell_id_d       = '0;
        pending_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_valid_q <= 1'b0;
      pending_seed_q  <= '0;
      seed_counter_q  <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      pending_valid_q <= pending_valid_d;
      pending_seed_q  <= pending_seed_d;
      seed_counter_q  <= seed_counter_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q      <= action_d;
    seed_number_q <= seed_number_d;
    cell_id_q     <= cell_id_d;
    if (step_i && ctl_i.have) begin
      range_low_q  <= lo_i;
      range_high_q <= hi_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = action_q;
  assign seed_number_o = seed_number_q;
  assign cell_id_o     = cell_id_q;
  assign range_low_o   = range_low_q;
  assign range_high_o  = range_high_q;

endmodule
`default_nettype wire
